FILE: src/hpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared constants, command codes and helper functions of the hex page loader.
// ----------------------------------------------------------------------------
package hpl_pkg;

    localparam int BUFFER_CHARS_DEF = 512;
    localparam int PAGE_BYTES_DEF   = 256;

    // One memory row holds one 64-bit word worth of characters
    localparam int LANES  = 8;
    localparam int CHAR_W = 8;

    localparam logic [1:0] FUNC_SET_PAGE = 2'd0;
    localparam logic [1:0] FUNC_APPEND   = 2'd1;
    localparam logic [1:0] FUNC_FINISH   = 2'd2;
    localparam logic [1:0] FUNC_REMAINS  = 2'd3;

    localparam logic [3:0] COUNT_MAX = 4'd8;

    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    typedef struct packed {
        logic clr_we;
        logic app_we;
        logic wb_we;
        logic rd_en;
    } hpl_mem_cmd_t;

    function automatic logic [3:0] sat_count(input logic [3:0] c);
        return (c > COUNT_MAX) ? COUNT_MAX : c;
    endfunction

    // Digits count as 0-9, anything else as c - 'A' + 10, wrapping at 8 bits
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            return c - CHAR_DIGIT_0;
        end
        return c - CHAR_UPPER_A + HEX_ALPHA_BASE;
    endfunction

endpackage
`default_nettype wire

FILE: src/hpl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/hpl_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_decode
// Converts sixteen ASCII hex characters into one little-endian 64-bit word.
// ----------------------------------------------------------------------------
module hpl_decode import hpl_pkg::*; (
    input  wire logic [2*LANES*CHAR_W-1:0] chars16,
    output logic      [LANES*CHAR_W-1:0]   word
);

    always_comb begin
        logic [7:0] hi_val;
        logic [7:0] lo_val;
        for (int b = 0; b < LANES; b++) begin
            hi_val = hex_value(chars16[(2*b)*CHAR_W +: CHAR_W]);
            lo_val = hex_value(chars16[(2*b+1)*CHAR_W +: CHAR_W]);
            word[b*CHAR_W +: CHAR_W] = {hi_val[3:0], 4'b0000} + lo_val;
        end
    end

endmodule
`default_nettype wire

FILE: src/hpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ctrl
// Command sequencer: fill position, page number, clearing pass, page-write
// read/decode/write-back loop and the output word register.
// ----------------------------------------------------------------------------
module hpl_ctrl import hpl_pkg::*; #(
    parameter int BUFFER_CHARS = BUFFER_CHARS_DEF,
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_func,
    input  wire logic [15:0]                          s_page,
    input  wire logic [3:0]                           s_count,
    output hpl_mem_cmd_t                              mem_cmd,
    output logic [$clog2(BUFFER_CHARS/LANES)-1:0]     clr_row,
    output logic [$clog2(BUFFER_CHARS/LANES)-1:0]     rd_row,
    output logic [$clog2(BUFFER_CHARS/LANES)-1:0]     wb_row,
    output logic [LANES*CHAR_W-1:0]                   wb_data,
    output logic [$clog2(BUFFER_CHARS+1)-1:0]         fill,
    input  wire logic [LANES*CHAR_W-1:0]              rd_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [15:0]                               m_out_page,
    output logic [4:0]                                m_word_index,
    output logic [63:0]                               m_word_data,
    output logic                                      m_last
);

    localparam int ROWS   = BUFFER_CHARS / LANES;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int WORDS  = PAGE_BYTES / LANES;
    localparam int WCNT_W = $clog2(WORDS);
    localparam int FILL_W = $clog2(BUFFER_CHARS + 1);
    localparam int CMP_W  = ((WCNT_W + 1) > ROW_W) ? (WCNT_W + 2) : (ROW_W + 1);
    localparam int WORD_W = LANES * CHAR_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD_HI = 3'd2;
    localparam logic [2:0] ST_RD_LO = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       page_reg, page_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic              rd_oob_reg, rd_oob_next;
    logic [WORD_W-1:0] hi_reg, hi_next;
    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_page_reg, m_page_next;
    logic [4:0]        m_index_reg, m_index_next;
    logic [63:0]       m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic [3:0]        cnt_sat;
    logic [FILL_W:0]   fill_sum;
    logic [FILL_W-1:0] fill_app;
    logic [WCNT_W:0]   rd_row_wide;
    logic              rd_oob;
    logic              out_free;
    logic              wb_in_range;
    logic              last_word;
    logic [WCNT_W-1:0] wcnt_inc;
    logic [WORD_W-1:0] lo_chars;
    logic [WORD_W-1:0] word;

    assign cnt_sat   = sat_count(s_count);
    assign fill_sum  = {1'b0, fill_reg} + (FILL_W+1)'(cnt_sat);
    assign fill_app  = (fill_sum > (FILL_W+1)'(BUFFER_CHARS)) ?
                       FILL_W'(BUFFER_CHARS) : fill_sum[FILL_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;
    assign last_word = (wcnt_reg == WCNT_W'(WORDS - 1));
    assign wcnt_inc  = wcnt_reg + 1'b1;
    assign wb_in_range = (CMP_W'(wcnt_reg) < CMP_W'(ROWS));
    assign rd_oob    = (CMP_W'(rd_row_wide) >= CMP_W'(ROWS));

    // Rows past the end of the buffer read as zero characters
    assign lo_chars = rd_oob_reg ? '0 : rd_data;

    hpl_decode u_decode (
        .chars16 ({lo_chars, hi_reg}),
        .word    (word)
    );

    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        fill_next    = fill_reg;
        page_next    = page_reg;
        wcnt_next    = wcnt_reg;
        rd_oob_next  = rd_oob_reg;
        hi_next      = hi_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_page_next  = m_page_reg;
        m_index_next = m_index_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        mem_cmd      = '0;
        rd_row_wide  = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_cmd.clr_we = 1'b1;
                clr_row_next   = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FUNC_SET_PAGE: begin
                            page_next    = s_page;
                            fill_next    = '0;
                            clr_row_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        FUNC_APPEND: begin
                            mem_cmd.app_we = 1'b1;
                            if (fill_app == FILL_W'(BUFFER_CHARS)) begin
                                fill_next  = '0;
                                wcnt_next  = '0;
                                state_next = ST_RD_HI;
                            end else begin
                                fill_next = fill_app;
                            end
                        end
                        FUNC_FINISH: begin
                            mem_cmd.app_we = 1'b1;
                            fill_next      = '0;
                            wcnt_next      = '0;
                            state_next     = ST_RD_HI;
                        end
                        default: begin
                            if (fill_reg != '0) begin
                                wcnt_next  = '0;
                                state_next = ST_RD_HI;
                            end
                        end
                    endcase
                end
            end
            ST_RD_HI: begin
                mem_cmd.rd_en = 1'b1;
                rd_row_wide   = {wcnt_reg, 1'b0};
                state_next    = ST_RD_LO;
            end
            ST_RD_LO: begin
                hi_next       = lo_chars;
                mem_cmd.rd_en = 1'b1;
                rd_row_wide   = {wcnt_reg, 1'b1};
                state_next    = ST_DEC;
            end
            ST_DEC: begin
                // Hold here until the output register can take the word
                if (out_free) begin
                    mem_cmd.wb_we = wb_in_range;
                    m_valid_next  = 1'b1;
                    m_page_next   = page_reg;
                    m_index_next  = 5'(wcnt_reg);
                    m_data_next   = word;
                    m_last_next   = last_word;
                    if (last_word) begin
                        page_next  = page_reg + 1'b1;
                        wcnt_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        wcnt_next     = wcnt_inc;
                        mem_cmd.rd_en = 1'b1;
                        rd_row_wide   = {wcnt_inc, 1'b0};
                        state_next    = ST_RD_LO;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_cmd.rd_en) begin
            rd_oob_next = rd_oob;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            fill_reg    <= '0;
            page_reg    <= '0;
            wcnt_reg    <= '0;
            rd_oob_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            fill_reg    <= fill_next;
            page_reg    <= page_next;
            wcnt_reg    <= wcnt_next;
            rd_oob_reg  <= rd_oob_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg      <= hi_next;
        m_page_reg  <= m_page_next;
        m_index_reg <= m_index_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign clr_row      = clr_row_reg;
    assign rd_row       = ROW_W'(rd_row_wide);
    assign wb_row       = ROW_W'(wcnt_reg);
    assign wb_data      = word;
    assign fill         = fill_reg;
    assign m_valid      = m_valid_reg;
    assign m_out_page   = m_page_reg;
    assign m_word_index = m_index_reg;
    assign m_word_data  = m_data_reg;
    assign m_last       = m_last_reg;

endmodule
`default_nettype wire

FILE: src/ascii_hex_page_loader.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_hex_page_loader
// Collects ASCII hex characters and emits decoded flash pages as 64-bit words.
// ----------------------------------------------------------------------------
// Input words carry a command (s_func), a page number, up to eight characters
// and a character count. Result words carry the page number, the word index,
// eight decoded bytes (lowest address in bits 7:0) and m_last on the final
// word of a page. Both channels use valid/ready.
// The character buffer sits in eight byte-lane RAMs of BUFFER_CHARS/8 rows,
// so an append stores up to eight characters in one write across the lanes.
// Set-page accepts the command and then runs a zeroing pass over all rows;
// an append without a page write needs no further pass. A page write reads
// the first word's rows in RD_HI and RD_LO, decodes it in DEC, then loops
// between RD_LO and DEC, as the single RAM read port fetches two rows per
// output word; m_valid rises once the first word has passed through DEC.
// After reset the block runs the same zeroing pass with s_ready low. A
// stalled receiver holds the output word register and freezes the
// page-write loop; s_ready stays low until the write is done.
// ----------------------------------------------------------------------------
module ascii_hex_page_loader import hpl_pkg::*; #(
    parameter int BUFFER_CHARS = BUFFER_CHARS_DEF,
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_page,
    input  wire logic [63:0] s_chars,
    input  wire logic [3:0]  s_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_out_page,
    output logic [4:0]       m_word_index,
    output logic [63:0]      m_word_data,
    output logic             m_last
);

    localparam int ROWS   = BUFFER_CHARS / LANES;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int FILL_W = $clog2(BUFFER_CHARS + 1);
    localparam int WORD_W = LANES * CHAR_W;

    hpl_mem_cmd_t      mem_cmd;
    logic [ROW_W-1:0]  clr_row;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  wb_row;
    logic [WORD_W-1:0] wb_data;
    logic [WORD_W-1:0] rd_data;
    logic [FILL_W-1:0] fill;
    logic [3:0]        cnt_sat;

    assign cnt_sat = sat_count(s_count);

    hpl_ctrl #(
        .BUFFER_CHARS (BUFFER_CHARS),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_page       (s_page),
        .s_count      (s_count),
        .mem_cmd      (mem_cmd),
        .clr_row      (clr_row),
        .rd_row       (rd_row),
        .wb_row       (wb_row),
        .wb_data      (wb_data),
        .fill         (fill),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_page   (m_out_page),
        .m_word_index (m_word_index),
        .m_word_data  (m_word_data),
        .m_last       (m_last)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [2:0]        off;
        logic [FILL_W:0]   pos;
        logic              app_en;
        logic              we;
        logic [ROW_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;

        // Character k of the word lands in lane (fill + k) mod 8
        assign off    = 3'(l) - fill[2:0];
        assign pos    = {1'b0, fill} + (FILL_W+1)'(off);
        assign app_en = mem_cmd.app_we && ({1'b0, off} < cnt_sat)
                        && (pos < (FILL_W+1)'(BUFFER_CHARS));

        always_comb begin
            we    = mem_cmd.clr_we || mem_cmd.wb_we || app_en;
            waddr = ROW_W'(pos >> 3);
            wdata = s_chars[{off, 3'b000} +: CHAR_W];
            if (mem_cmd.clr_we) begin
                waddr = clr_row;
                wdata = '0;
            end else if (mem_cmd.wb_we) begin
                waddr = wb_row;
                wdata = wb_data[l*CHAR_W +: CHAR_W];
            end
        end

        hpl_ram #(
            .WIDTH (CHAR_W),
            .DEPTH (ROWS)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (mem_cmd.rd_en),
            .raddr (rd_row),
            .rdata (rd_data[l*CHAR_W +: CHAR_W])
        );
    end

endmodule
`default_nettype wire

FILE: src/hpl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_checker
// Port-level assertions for the hex page loader, bound to the top level.
// ----------------------------------------------------------------------------
module hpl_checker import hpl_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_func,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [4:0]  m_word_index,
    input wire logic [63:0] m_word_data,
    input wire logic        m_last
);

    localparam int WORDS = PAGE_BYTES / LANES;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_data)
                                && $stable(m_word_index) && $stable(m_last))
        else $error("result word changed while stalled");

    // Finish always starts a page write, which blocks the input
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_FINISH |=> !s_ready)
        else $error("input ready right after finish");

    // Set page starts the zeroing pass
    a_set_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_SET_PAGE |=> !s_ready)
        else $error("input ready right after set page");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_word_index == 5'(WORDS - 1))
        else $error("last flag on wrong word index");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block active right after reset");

endmodule

bind ascii_hex_page_loader hpl_checker #(
    .PAGE_BYTES (PAGE_BYTES)
) u_hpl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_func       (s_func),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_word_index (m_word_index),
    .m_word_data  (m_word_data),
    .m_last       (m_last)
);
`default_nettype wire
